FILE: rtl/core/path_point_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Path point interpolator assertion macros
// Concurrent assertion wrappers used by the interpolator top module.
// ----------------------------------------------------------------------------
`ifndef PATH_POINT_INTERPOLATOR_MACROS_SVH
`define PATH_POINT_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PPI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppi assertion failed");
`define PPI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppi assertion failed");
`else
`define PPI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PPI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/ppi_pkg.sv
// ----------------------------------------------------------------------------
// Path point interpolator package
// Operation codes, node and command types and fixed widths.
// ----------------------------------------------------------------------------
package ppi_pkg;

    localparam int POS_W      = 17;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int FRAC_W     = 17;
    localparam int FRAC_SH    = 16;
    localparam int PROD_W     = DIFF_W + FRAC_W + 1;
    localparam int DIV_STEPS  = FRAC_W;
    localparam int LERP_STEPS = 5;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic [POS_W-1:0]          key;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
    } t_node;

    typedef struct packed {
        logic  rd_en;
        logic  capture;
        logic  res_clear;
        logic  res_load_cur;
        logic  div_init;
        logic  div_step;
        logic  sub_en;
        t_axis sub_axis;
        logic  mul_en;
        logic  add_en;
        t_axis add_axis;
    } t_cmd;

    typedef struct packed {
        logic key_hit;
    } t_status;

endpackage

FILE: rtl/core/ppi_ctrl.sv
// ----------------------------------------------------------------------------
// Path point interpolator controller
// Sequences requests, the node scan, the serial divide and the blend steps.
// ----------------------------------------------------------------------------
module ppi_ctrl #(
    parameter int MAX_NODES = 64,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_operation,
    input  ppi_pkg::t_status   i_status,
    output ppi_pkg::t_cmd      o_cmd,
    output logic [IDX_W-1:0]   o_rd_addr,
    output logic [IDX_W-1:0]   o_wr_addr,
    output logic               o_wr_en,
    output logic               o_valid,
    output logic [CNT_W-1:0]   o_node_total,
    output logic               o_table_empty,
    output logic               o_append_dropped
);
    import ppi_pkg::*;

    localparam int NUM_AXES = 3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_LERP
    } t_state;

    t_state             r_state,   n_state;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic [IDX_W-1:0]   r_idx,     n_idx;
    logic [STEP_W-1:0]  r_step,    n_step;
    logic               r_valid,   n_valid;
    logic               r_empty,   n_empty;
    logic               r_dropped, n_dropped;
    logic               accept;
    logic               at_last;
    logic               full;
    logic [STEP_W-1:0]  add_step;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign at_last  = CNT_W'(r_idx) == (r_count - CNT_W'(1));
    assign full     = r_count == CNT_W'(MAX_NODES);
    assign add_step = r_step - STEP_W'(2);

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_step    = r_step;
        n_valid   = 1'b0;
        n_empty   = r_empty;
        n_dropped = r_dropped;
        o_cmd     = '0;
        o_rd_addr = r_idx + IDX_W'(1);
        o_wr_addr = r_count[IDX_W-1:0];
        o_wr_en   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.res_clear = 1'b1;
                    n_empty         = 1'b0;
                    n_dropped       = 1'b0;
                    case (t_op'(i_operation))
                        OP_CLEAR: begin
                            n_count = '0;
                            n_valid = 1'b1;
                        end
                        OP_APPEND: begin
                            n_valid = 1'b1;
                            if (full) begin
                                n_dropped = 1'b1;
                            end else begin
                                o_wr_en = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            if (r_count == '0) begin
                                n_empty = 1'b1;
                                n_valid = 1'b1;
                            end else begin
                                o_cmd.rd_en = 1'b1;
                                o_rd_addr   = '0;
                                n_idx       = '0;
                                n_state     = ST_SCAN;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_status.key_hit) begin
                    if (r_idx == '0) begin
                        o_cmd.res_load_cur = 1'b1;
                        n_valid            = 1'b1;
                        n_state            = ST_IDLE;
                    end else begin
                        o_cmd.div_init = 1'b1;
                        n_step         = '0;
                        n_state        = ST_DIV;
                    end
                end else if (at_last) begin
                    o_cmd.res_load_cur = 1'b1;
                    n_valid            = 1'b1;
                    n_state            = ST_IDLE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + IDX_W'(1);
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = ST_LERP;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_LERP: begin
                o_cmd.sub_en   = r_step < STEP_W'(NUM_AXES);
                o_cmd.sub_axis = t_axis'(r_step[1:0]);
                o_cmd.mul_en   = (r_step >= STEP_W'(1)) && (r_step <= STEP_W'(NUM_AXES));
                o_cmd.add_en   = r_step >= STEP_W'(2);
                o_cmd.add_axis = t_axis'(add_step[1:0]);
                if (r_step == STEP_W'(LERP_STEPS - 1)) begin
                    n_step  = '0;
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_step    <= '0;
            r_valid   <= 1'b0;
            r_empty   <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_step    <= n_step;
            r_valid   <= n_valid;
            r_empty   <= n_empty;
            r_dropped <= n_dropped;
        end
    end

    assign o_busy           = r_state != ST_IDLE;
    assign o_valid          = r_valid;
    assign o_node_total     = r_count;
    assign o_table_empty    = r_empty;
    assign o_append_dropped = r_dropped;

endmodule

FILE: rtl/core/ppi_datapath.sv
// ----------------------------------------------------------------------------
// Path point interpolator datapath
// Node memory, scan registers, serial fraction divider and shared blend unit.
// ----------------------------------------------------------------------------
module ppi_datapath #(
    parameter int MAX_NODES = 64,
    parameter int IDX_W     = 6
) (
    input  logic                                 i_clk,
    input  ppi_pkg::t_cmd                        i_cmd,
    output ppi_pkg::t_status                     o_status,
    input  logic [IDX_W-1:0]                     i_rd_addr,
    input  logic [IDX_W-1:0]                     i_wr_addr,
    input  logic                                 i_wr_en,
    input  logic [ppi_pkg::POS_W-1:0]            i_position,
    input  logic signed [ppi_pkg::COORD_W-1:0]   i_coord_x,
    input  logic signed [ppi_pkg::COORD_W-1:0]   i_coord_y,
    input  logic signed [ppi_pkg::COORD_W-1:0]   i_coord_z,
    output logic signed [ppi_pkg::COORD_W-1:0]   o_point_x,
    output logic signed [ppi_pkg::COORD_W-1:0]   o_point_y,
    output logic signed [ppi_pkg::COORD_W-1:0]   o_point_z
);
    import ppi_pkg::*;

    function automatic logic signed [COORD_W-1:0] f_coord(input t_node n, input t_axis a);
        case (a)
            AXIS_X:  f_coord = n.px;
            AXIS_Y:  f_coord = n.py;
            AXIS_Z:  f_coord = n.pz;
            default: f_coord = n.px;
        endcase
    endfunction

    t_node                      r_mem [MAX_NODES];
    t_node                      r_cur;
    t_node                      r_prev;
    logic [POS_W-1:0]           r_pos;
    logic [POS_W:0]             r_rem;
    logic [POS_W-1:0]           r_span;
    logic [FRAC_W-1:0]          r_quo;
    logic signed [DIFF_W-1:0]   r_diff;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [COORD_W-1:0]  r_res_x;
    logic signed [COORD_W-1:0]  r_res_y;
    logic signed [COORD_W-1:0]  r_res_z;

    logic                       fits;
    logic [POS_W:0]             rem_left;
    logic signed [COORD_W-1:0]  sub_cur;
    logic signed [COORD_W-1:0]  sub_prev;
    logic signed [COORD_W-1:0]  add_prev;
    logic signed [COORD_W-1:0]  blended;

    assign o_status.key_hit = r_cur.key >= r_pos;

    assign fits     = r_rem >= {1'b0, r_span};
    assign rem_left = fits ? (r_rem - {1'b0, r_span}) : r_rem;
    assign sub_cur  = f_coord(r_cur, i_cmd.sub_axis);
    assign sub_prev = f_coord(r_prev, i_cmd.sub_axis);
    assign add_prev = f_coord(r_prev, i_cmd.add_axis);
    assign blended  = add_prev + r_prod[FRAC_SH +: COORD_W];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= '{key: i_position, px: i_coord_x, py: i_coord_y,
                                  pz: i_coord_z};
        end
        if (i_cmd.rd_en) begin
            r_cur  <= r_mem[i_rd_addr];
            r_prev <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos <= i_position;
        end
        if (i_cmd.div_init) begin
            r_rem  <= {1'b0, r_pos - r_prev.key};
            r_span <= r_cur.key - r_prev.key;
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= {rem_left[POS_W-1:0], 1'b0};
            r_quo  <= {r_quo[FRAC_W-2:0], fits};
        end
        if (i_cmd.sub_en) begin
            r_diff <= $signed({sub_cur[COORD_W-1], sub_cur})
                    - $signed({sub_prev[COORD_W-1], sub_prev});
        end
        if (i_cmd.mul_en) begin
            r_prod <= r_diff * $signed({1'b0, r_quo});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_clear) begin
            r_res_x <= '0;
            r_res_y <= '0;
            r_res_z <= '0;
        end else if (i_cmd.res_load_cur) begin
            r_res_x <= r_cur.px;
            r_res_y <= r_cur.py;
            r_res_z <= r_cur.pz;
        end else if (i_cmd.add_en) begin
            case (i_cmd.add_axis)
                AXIS_X:  r_res_x <= blended;
                AXIS_Y:  r_res_y <= blended;
                AXIS_Z:  r_res_z <= blended;
                default: r_res_x <= r_res_x;
            endcase
        end
    end

    assign o_point_x = r_res_x;
    assign o_point_y = r_res_y;
    assign o_point_z = r_res_z;

endmodule

FILE: rtl/core/path_point_interpolator.sv
// A query that blends two nodes returns its result after the scan, the divide and the blend;
// one answered by a single node returns it straight from the scan.
// The scan reads one node per cycle through the node memory read port, then a 17-step
// serial divider and a shared multiplier finish the blend.
// One request at a time; others answer in the next cycle; o_valid is never stalled.
// Synchronous active-low reset empties the table; the node memory itself is not cleared.
// ----------------------------------------------------------------------------
// Path point interpolator
// Piecewise linear interpolation over a table of appended path nodes.
// ----------------------------------------------------------------------------
`include "path_point_interpolator_macros.svh"

module path_point_interpolator #(
    parameter int MAX_NODES = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              i_operation,
    input  logic [ppi_pkg::POS_W-1:0]               i_position,
    input  logic signed [ppi_pkg::COORD_W-1:0]      i_coord_x,
    input  logic signed [ppi_pkg::COORD_W-1:0]      i_coord_y,
    input  logic signed [ppi_pkg::COORD_W-1:0]      i_coord_z,
    output logic                                    o_valid,
    output logic signed [ppi_pkg::COORD_W-1:0]      o_point_x,
    output logic signed [ppi_pkg::COORD_W-1:0]      o_point_y,
    output logic signed [ppi_pkg::COORD_W-1:0]      o_point_z,
    output logic [$clog2(MAX_NODES+1)-1:0]          o_node_total,
    output logic                                    o_table_empty,
    output logic                                    o_append_dropped
);
    import ppi_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    t_cmd               cmd;
    t_status            status;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;

    ppi_ctrl #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_operation      (i_operation),
        .i_status         (status),
        .o_cmd            (cmd),
        .o_rd_addr        (rd_addr),
        .o_wr_addr        (wr_addr),
        .o_wr_en          (wr_en),
        .o_valid          (o_valid),
        .o_node_total     (o_node_total),
        .o_table_empty    (o_table_empty),
        .o_append_dropped (o_append_dropped)
    );

    ppi_datapath #(
        .MAX_NODES (MAX_NODES),
        .IDX_W     (IDX_W)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_rd_addr  (rd_addr),
        .i_wr_addr  (wr_addr),
        .i_wr_en    (wr_en),
        .i_position (i_position),
        .i_coord_x  (i_coord_x),
        .i_coord_y  (i_coord_y),
        .i_coord_z  (i_coord_z),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_point_z  (o_point_z)
    );

    `PPI_ASSERT_NEXT(a_quick_answer, i_clk, i_rst_n, start && !busy && i_operation != OP_QUERY, o_valid)
    `PPI_ASSERT_SAME(a_valid_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `PPI_ASSERT_SAME(a_empty_is_zero, i_clk, i_rst_n, o_valid && o_table_empty, o_node_total == '0 && o_point_x == '0)
    `PPI_ASSERT_SAME(a_drop_when_full, i_clk, i_rst_n, o_valid && o_append_dropped, o_node_total == CNT_W'(MAX_NODES))

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path point interpolator testbench
// Drives clear, append and query requests through the start/busy handshake.
// A predictor in the bench mirrors the node table and works out each result.
// Every result strobe is checked field by field against the oldest pending
// prediction. Directed cases come first: an empty table, the table edges,
// exact keys, positions above one, unsorted keys, a full table and the
// unused operation code. Random path sequences follow under three
// sender idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import ppi_pkg::*;

    localparam int NODE_CAP      = 64;
    localparam int TOTAL_W       = $clog2(NODE_CAP + 1);
    localparam int SETTLE_CYCLES = NODE_CAP + 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [1:0]               OP_UNUSED = 2'd3;
    localparam logic [POS_W-1:0]         POS_ONE   = 17'h10000;
    localparam logic [POS_W-1:0]         POS_MAX   = 17'h1FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic [TOTAL_W-1:0]        total;
        logic                      empty;
        logic                      dropped;
    } t_path_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [1:0]                 i_operation;
    logic [POS_W-1:0]           i_position;
    logic signed [COORD_W-1:0]  i_coord_x;
    logic signed [COORD_W-1:0]  i_coord_y;
    logic signed [COORD_W-1:0]  i_coord_z;
    logic                       o_valid;
    logic signed [COORD_W-1:0]  o_point_x;
    logic signed [COORD_W-1:0]  o_point_y;
    logic signed [COORD_W-1:0]  o_point_z;
    logic [TOTAL_W-1:0]         o_node_total;
    logic                       o_table_empty;
    logic                       o_append_dropped;

    logic [POS_W-1:0]           path_key [NODE_CAP];
    logic signed [COORD_W-1:0]  path_px  [NODE_CAP];
    logic signed [COORD_W-1:0]  path_py  [NODE_CAP];
    logic signed [COORD_W-1:0]  path_pz  [NODE_CAP];
    int                         path_count;
    t_path_result               expected_points [$];

    int requests_sent;
    int results_seen;
    int mismatch_count;
    int blended_queries;
    int end_node_queries;
    int empty_queries;
    int dropped_appends;
    int unused_requests;
    int idle_pct;
    int stall_cycles;
    int leftover;
    t_path_result seen_point;
    t_path_result want_point;

    path_point_interpolator #(
        .MAX_NODES(NODE_CAP)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .o_valid         (o_valid),
        .o_point_x       (o_point_x),
        .o_point_y       (o_point_y),
        .o_point_z       (o_point_z),
        .o_node_total    (o_node_total),
        .o_table_empty   (o_table_empty),
        .o_append_dropped(o_append_dropped)
    );

    always #6 i_clk = ~i_clk;

    function automatic logic signed [COORD_W-1:0] blend_coord(
        logic signed [COORD_W-1:0] from_c,
        logic signed [COORD_W-1:0] to_c,
        longint                    frac
    );
        longint sum;
        sum = longint'(from_c) + (((longint'(to_c) - longint'(from_c)) * frac) >>> FRAC_SH);
        return sum[COORD_W-1:0];
    endfunction

    function automatic t_path_result predict_point(
        logic [1:0]                op,
        logic [POS_W-1:0]          pos,
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] z
    );
        t_path_result res;
        int           hit;
        int           prev;
        longint       frac;
        res = '0;
        hit = -1;
        case (op)
            OP_CLEAR: begin
                path_count = 0;
            end
            OP_APPEND: begin
                if (path_count < NODE_CAP) begin
                    path_key[path_count] = pos;
                    path_px[path_count]  = x;
                    path_py[path_count]  = y;
                    path_pz[path_count]  = z;
                    path_count++;
                end else begin
                    res.dropped = 1'b1;
                    dropped_appends++;
                end
            end
            OP_QUERY: begin
                if (path_count == 0) begin
                    res.empty = 1'b1;
                    empty_queries++;
                end else begin
                    for (int i = path_count - 1; i >= 0; i--) begin
                        if (path_key[i] >= pos) begin
                            hit = i;
                        end
                    end
                    if (hit <= 0) begin
                        prev = (hit < 0) ? path_count - 1 : 0;
                        res.px = path_px[prev];
                        res.py = path_py[prev];
                        res.pz = path_pz[prev];
                        end_node_queries++;
                    end else begin
                        prev = hit - 1;
                        frac = ((longint'(pos) - longint'(path_key[prev])) <<< FRAC_SH)
                               / (longint'(path_key[hit]) - longint'(path_key[prev]));
                        res.px = blend_coord(path_px[prev], path_px[hit], frac);
                        res.py = blend_coord(path_py[prev], path_py[hit], frac);
                        res.pz = blend_coord(path_pz[prev], path_pz[hit], frac);
                        blended_queries++;
                    end
                end
            end
            default: begin
                unused_requests++;
            end
        endcase
        res.total = TOTAL_W'(path_count);
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 15))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3:       return COORD_W'($urandom_range(0, 65536 * 4)) - 32'sd131072;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] query_position();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2 && path_count > 0) begin
            return path_key[$urandom_range(0, path_count - 1)];
        end else if (pick == 2) begin
            return POS_W'($urandom_range(32'h10001, 32'h1FFFF));
        end
        return POS_W'($urandom_range(0, 65536));
    endfunction

    task automatic send_request(
        logic [1:0]                op,
        logic [POS_W-1:0]          pos,
        logic signed [COORD_W-1:0] x,
        logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] z
    );
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start       <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_coord_x   <= x;
        i_coord_y   <= y;
        i_coord_z   <= z;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        expected_points = {expected_points, predict_point(op, pos, x, y, z)};
        requests_sent++;
    endtask

    task automatic await_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_points.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(string what, t_path_result want, t_path_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s at %0t: expected x=%h y=%h z=%h total=%0d empty=%b dropped=%b",
                     what, $time, want.px, want.py, want.pz, want.total, want.empty,
                     want.dropped);
            $display("    got x=%h y=%h z=%h total=%0d empty=%b dropped=%b",
                     got.px, got.py, got.pz, got.total, got.empty, got.dropped);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            results_seen++;
            seen_point = {o_point_x, o_point_y, o_point_z, o_node_total, o_table_empty,
                          o_append_dropped};
            if (expected_points.size() == 0) begin
                note_mismatch("Unexpected result", '0, seen_point);
            end else begin
                want_point = expected_points.pop_front();
                if (seen_point.px !== want_point.px || seen_point.py !== want_point.py ||
                    seen_point.pz !== want_point.pz ||
                    seen_point.total !== want_point.total ||
                    seen_point.empty !== want_point.empty ||
                    seen_point.dropped !== want_point.dropped) begin
                    note_mismatch("Result mismatch", want_point, seen_point);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Timed out after %0d cycles without progress", stall_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(OP_QUERY, '0, rand_coord(), rand_coord(), rand_coord());
        send_request(OP_UNUSED, POS_MAX, COORD_MAX, COORD_MIN, '1);
        send_request(OP_APPEND, '0, COORD_MAX, COORD_MIN, '0);
        send_request(OP_QUERY, '0, '0, '0, '0);
        send_request(OP_QUERY, 17'd1, '0, '0, '0);
        send_request(OP_APPEND, POS_ONE, COORD_MIN, COORD_MAX, '1);
        send_request(OP_QUERY, 17'd1, '0, '0, '0);
        send_request(OP_QUERY, 17'h08000, '0, '0, '0);
        send_request(OP_QUERY, 17'h0FFFF, '0, '0, '0);
        send_request(OP_QUERY, POS_ONE, '0, '0, '0);
        send_request(OP_QUERY, POS_MAX, '0, '0, '0);
        send_request(OP_APPEND, 17'd100, 32'sh0005_0000, -32'sh0003_0000, 32'sh0000_8000);
        send_request(OP_APPEND, 17'd100, -32'sh0001_0000, 32'sh7FFF_0000, COORD_MIN);
        send_request(OP_QUERY, 17'd50, '0, '0, '0);
        send_request(OP_QUERY, 17'h10001, '0, '0, '0);
        send_request(OP_UNUSED, 17'd7, rand_coord(), rand_coord(), rand_coord());
        send_request(OP_CLEAR, POS_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(OP_QUERY, POS_ONE, '0, '0, '0);
        send_request(OP_APPEND, POS_ONE, '0, COORD_MAX, COORD_MIN);
        send_request(OP_APPEND, POS_MAX, COORD_MAX, COORD_MIN, '0);
        send_request(OP_QUERY, 17'h18000, '0, '0, '0);
        send_request(OP_QUERY, 17'h0FFFF, '0, '0, '0);
        send_request(OP_CLEAR, '0, '0, '0, '0);
    endtask

    task automatic test_full_table();
        send_request(OP_CLEAR, '0, '0, '0, '0);
        for (int n = 0; n < NODE_CAP; n++) begin
            send_request(OP_APPEND, POS_W'(n * 1024 + 64), rand_coord(), rand_coord(),
                         rand_coord());
        end
        send_request(OP_APPEND, POS_MAX, COORD_MAX, COORD_MIN, '1);
        send_request(OP_APPEND, '0, '0, '0, '0);
        send_request(OP_QUERY, POS_W'((NODE_CAP - 1) * 1024), '0, '0, '0);
        send_request(OP_QUERY, POS_W'((NODE_CAP - 1) * 1024 + 64), '0, '0, '0);
        send_request(OP_QUERY, POS_MAX, '0, '0, '0);
        send_request(OP_QUERY, 17'd64, '0, '0, '0);
        send_request(OP_UNUSED, '0, '0, '0, '0);
        send_request(OP_APPEND, 17'd5, rand_coord(), rand_coord(), rand_coord());
        send_request(OP_CLEAR, '0, '0, '0, '0);
    endtask

    task automatic test_random_paths(int budget);
        int first_sent;
        int nodes;
        int queries;
        int key_val;
        first_sent = requests_sent;
        while (requests_sent - first_sent < budget) begin
            if ($urandom_range(0, 9) < 7) begin
                send_request(OP_CLEAR, POS_W'($urandom), rand_coord(), rand_coord(),
                             rand_coord());
                if ($urandom_range(0, 11) == 0) begin
                    nodes = $urandom_range(9, NODE_CAP + 2);
                end else begin
                    nodes = $urandom_range(1, 6);
                end
                key_val = $urandom_range(0, 4096);
                for (int n = 0; n < nodes; n++) begin
                    send_request(OP_APPEND, POS_W'(key_val), rand_coord(), rand_coord(),
                                 rand_coord());
                    key_val += $urandom_range(0, 2 * 65536 / nodes);
                    if (key_val > 65536) begin
                        key_val = 65536;
                    end
                end
                queries = $urandom_range(1, 6);
                for (int q = 0; q < queries; q++) begin
                    send_request(OP_QUERY, query_position(), rand_coord(), rand_coord(),
                                 rand_coord());
                end
            end else begin
                send_request(2'($urandom), POS_W'($urandom), rand_coord(), rand_coord(),
                             rand_coord());
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_operation = OP_CLEAR;
        i_position  = '0;
        i_coord_x   = '0;
        i_coord_y   = '0;
        i_coord_z   = '0;
        idle_pct    = 33;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        await_results();
        test_full_table();
        await_results();
        test_random_paths(560);
        await_results();
        idle_pct = 76;
        test_random_paths(560);
        await_results();
        idle_pct = 0;
        test_random_paths(560);
        await_results();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        leftover = expected_points.size();
        if (leftover != 0) begin
            $display("%0d expected results never arrived", leftover);
        end
        $display("Ran %0d requests: %0d blended, %0d end-node, %0d on an empty table.",
                 requests_sent, blended_queries, end_node_queries, empty_queries);
        $display("Dropped appends %0d, unused operations %0d, checked %0d, mismatches %0d.",
                 dropped_appends, unused_requests, results_seen, mismatch_count);
        if (mismatch_count == 0 && leftover == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/ppi_pkg.sv
rtl/core/ppi_ctrl.sv
rtl/core/ppi_datapath.sv
rtl/core/path_point_interpolator.sv
test/tb.sv
